@@ design/gdp_pkg.sv @@
// Shared constants for the graph degree parity engine.
package gdp_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int CMD_W = 2;
    localparam int VTX_W = 4;
    localparam int CNT_W = 5;
    localparam int DEG_W = 5;
    localparam int EC_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEGREE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EULER  = 2'd3;

    localparam logic [ST_W-1:0] STAT_OK     = 2'd0;
    localparam logic [ST_W-1:0] STAT_ABSENT = 2'd1;
    localparam logic [ST_W-1:0] STAT_RANGE  = 2'd2;

    localparam logic [EC_W-1:0] EC_EULERIAN = 2'd0;
    localparam logic [EC_W-1:0] EC_SEMI     = 2'd1;
    localparam logic [EC_W-1:0] EC_NOT      = 2'd2;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 5'd16;

endpackage

@@ design/gdp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module gdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/graph_degree_parity_engine.sv @@
// Graph degree parity engine: adjacency matrix in RAM, edge edits, degree and Euler scans.
//
// Use: items enter on the s_ stream (command, vertex_a, vertex_b) and each item
// gives exactly one result item on the m_ stream (degree, euler_class, status).
// Users must write vertex_count via cfg_wen/cfg_wdata only while idle; the block does not check.
// One item is worked on at a time; s_tready is high only while no item is in work.
// Steps per item (the row RAM gives one read per cycle, with registered read data):
//   insert/remove, distinct endpoints: write a / read b, write b,
//   result; self loop: write a, result; absent edge: read a, result;
//   degree query: count row a, result; out-of-range vertex: result only;
//   Euler classification: one row per counted vertex, then result (result only if count is 0).
// The block returns to idle as the result register loads, ready for the next item.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls with a result still held, a finished item waits in its
// last state until the output register frees up.
// Reset (aresetn low, synchronous) clears the control state, the per-row valid
// bits (so every row reads as empty at once) and sets vertex_count to 16.
module graph_degree_parity_engine #(
    parameter int MAX_VERTICES = gdp_pkg::MAX_VERTICES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wen,
    input  logic [gdp_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command[1:0], vertex_a[5:2], vertex_b[9:6], zero padding[15:10]
    input  logic [15:0]               s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // degree[4:0], euler_class[6:5], status[8:7], zero padding[15:9]
    output logic [15:0]               m_tdata
);
    import gdp_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int IW   = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam int MAXC = (MAX_VERTICES > 31) ? 31 : MAX_VERTICES;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_DEG  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    function automatic logic [AW-1:0] to_addr(input logic [VTX_W-1:0] v);
        logic [AW+VTX_W-1:0] ext;
        ext = {{AW{1'b0}}, v};
        return ext[AW-1:0];
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        vcount_reg;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [VTX_W-1:0]        va_reg, va_next, vb_reg, vb_next;
    logic [AW-1:0]           scan_reg, scan_next;
    logic [1:0]              odd_reg, odd_next;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rvalid_reg;
    logic [DEG_W-1:0]        res_deg_reg, res_deg_next;
    logic [EC_W-1:0]         res_ec_reg, res_ec_next;
    logic [ST_W-1:0]         res_st_reg, res_st_next;
    logic                    m_tvalid_reg;
    logic [DEG_W-1:0]        out_deg_reg;
    logic [EC_W-1:0]         out_ec_reg;
    logic [ST_W-1:0]         out_st_reg;

    logic [CMD_W-1:0]        in_cmd;
    logic [VTX_W-1:0]        in_a, in_b;
    logic [CNT_W-1:0]        cnt;
    logic [MAX_VERTICES-1:0] col_mask, one, row, row_m, bit_a, bit_b, wdata;
    logic                    accept, out_free, a_ok, b_ok, we, parity;
    logic [AW-1:0]           raddr, waddr;
    logic [MAX_VERTICES-1:0] rdata;
    logic [DEG_W-1:0]        pop;

    assign in_cmd = s_tdata[1:0];
    assign in_a   = s_tdata[5:2];
    assign in_b   = s_tdata[9:6];

    assign cnt = (vcount_reg > CNT_W'(MAXC)) ? CNT_W'(MAXC) : vcount_reg;

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            col_mask[i] = (IW'(i) < IW'(cnt));
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign a_ok     = ({1'b0, in_a} < cnt);
    assign b_ok     = ({1'b0, in_b} < cnt);

    // Rows never written since reset read as empty.
    assign row   = rvalid_reg ? rdata : '0;
    assign row_m = row & col_mask;
    assign one   = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    assign bit_a = one << va_reg;
    assign bit_b = one << vb_reg;

    assign parity = ^row_m;
    always_comb begin
        pop = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            pop = pop + DEG_W'(row_m[i]);
        end
    end

    gdp_ram #(
        .WIDTH(MAX_VERTICES),
        .DEPTH(MAX_VERTICES)
    ) u_rows (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        scan_next    = scan_reg;
        odd_next     = odd_reg;
        res_deg_next = res_deg_reg;
        res_ec_next  = res_ec_reg;
        res_st_next  = res_st_reg;
        raddr        = '0;
        waddr        = to_addr(va_reg);
        wdata        = row | bit_b;
        we           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                raddr = to_addr(in_a);
                if (accept) begin
                    cmd_next     = in_cmd;
                    va_next      = in_a;
                    vb_next      = in_b;
                    res_deg_next = '0;
                    res_ec_next  = EC_EULERIAN;
                    res_st_next  = STAT_OK;
                    case (in_cmd)
                        CMD_INSERT, CMD_REMOVE: begin
                            if (a_ok && b_ok) begin
                                state_next = S_RDA;
                            end else begin
                                res_st_next = STAT_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        CMD_DEGREE: begin
                            if (a_ok) begin
                                state_next = S_DEG;
                            end else begin
                                res_st_next = STAT_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default: begin
                            raddr     = '0;
                            scan_next = '0;
                            odd_next  = '0;
                            state_next = (cnt == '0) ? S_DONE : S_SCAN;
                        end
                    endcase
                end
            end
            S_RDA: begin
                raddr = to_addr(vb_reg);
                waddr = to_addr(va_reg);
                if (cmd_reg == CMD_INSERT) begin
                    wdata = row | bit_b;
                    we    = 1'b1;
                    state_next = (va_reg == vb_reg) ? S_DONE : S_RDB;
                end else if ((row & bit_b) == '0) begin
                    res_st_next = STAT_ABSENT;
                    state_next  = S_DONE;
                end else begin
                    wdata = row & ~bit_b;
                    we    = 1'b1;
                    state_next = (va_reg == vb_reg) ? S_DONE : S_RDB;
                end
            end
            S_RDB: begin
                waddr = to_addr(vb_reg);
                wdata = (cmd_reg == CMD_INSERT) ? (row | bit_a) : (row & ~bit_a);
                we    = 1'b1;
                state_next = S_DONE;
            end
            S_DEG: begin
                res_deg_next = pop;
                state_next   = S_DONE;
            end
            S_SCAN: begin
                // odd count saturates at 3: only zero, two and other matter
                if (parity && odd_reg != 2'd3) begin
                    odd_next = odd_reg + 2'd1;
                end
                if (IW'(scan_reg) + IW'(1) == IW'(cnt)) begin
                    if (odd_next == 2'd0) begin
                        res_ec_next = EC_EULERIAN;
                    end else if (odd_next == 2'd2) begin
                        res_ec_next = EC_SEMI;
                    end else begin
                        res_ec_next = EC_NOT;
                    end
                    state_next = S_DONE;
                end else begin
                    scan_next = scan_reg + AW'(1);
                    raddr     = scan_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= VCOUNT_RESET;
            row_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                vcount_reg <= cfg_wdata;
            end
            if (we) begin
                row_valid_reg[waddr] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        scan_reg    <= scan_next;
        odd_reg     <= odd_next;
        res_deg_reg <= res_deg_next;
        res_ec_reg  <= res_ec_next;
        res_st_reg  <= res_st_next;
        rvalid_reg  <= row_valid_reg[raddr];
        if (state_reg == S_DONE && out_free) begin
            out_deg_reg <= res_deg_reg;
            out_ec_reg  <= res_ec_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_st_reg, out_ec_reg, out_deg_reg};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for graph_degree_parity_engine: directed and random stream traffic with a scoreboard.
import gdp_pkg::*;

typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [EC_W-1:0]  euler_class;
    logic [DEG_W-1:0] degree;
} graph_result_t;

class degree_parity_board;
    logic [MAX_VERTICES_DEF-1:0] adj_rows [MAX_VERTICES_DEF];
    logic [CNT_W-1:0]            vertex_count;
    graph_result_t               expected_results [$];
    int                          errors;

    function new();
        foreach (adj_rows[i]) adj_rows[i] = '0;
        vertex_count = VCOUNT_RESET;
        errors = 0;
    endfunction

    function void set_vertex_count(logic [CNT_W-1:0] value);
        vertex_count = value;
    endfunction

    function int active_count();
        return (vertex_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vertex_count);
    endfunction

    function logic [MAX_VERTICES_DEF-1:0] column_mask();
        int cnt;
        cnt = active_count();
        if (cnt >= MAX_VERTICES_DEF) return '1;
        return (MAX_VERTICES_DEF'(1) << cnt) - 1'b1;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // a neighbor of v among the columns in use, or any vertex when there is none
    function logic [VTX_W-1:0] pick_neighbor(logic [VTX_W-1:0] v);
        logic [MAX_VERTICES_DEF-1:0] row;
        int start;
        row = adj_rows[v] & column_mask();
        start = $urandom_range(0, MAX_VERTICES_DEF - 1);
        for (int k = 0; k < MAX_VERTICES_DEF; k++) begin
            if (row[(start + k) % MAX_VERTICES_DEF]) return VTX_W'((start + k) % MAX_VERTICES_DEF);
        end
        return VTX_W'($urandom_range(0, MAX_VERTICES_DEF - 1));
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] va,
                               logic [VTX_W-1:0] vb);
        int cnt;
        int odd_rows;
        logic [MAX_VERTICES_DEF-1:0] mask;
        graph_result_t res;
        cnt = active_count();
        mask = column_mask();
        res = '0;
        res.status = STAT_OK;
        case (cmd)
            CMD_INSERT, CMD_REMOVE: begin
                if (va >= cnt || vb >= cnt) begin
                    res.status = STAT_RANGE;
                end else if (cmd == CMD_INSERT) begin
                    adj_rows[va][vb] = 1'b1;
                    adj_rows[vb][va] = 1'b1;
                end else if (!adj_rows[va][vb]) begin
                    res.status = STAT_ABSENT;
                end else begin
                    adj_rows[va][vb] = 1'b0;
                    adj_rows[vb][va] = 1'b0;
                end
            end
            CMD_DEGREE: begin
                if (va >= cnt) res.status = STAT_RANGE;
                else res.degree = DEG_W'($countones(adj_rows[va] & mask));
            end
            default: begin
                odd_rows = 0;
                for (int r = 0; r < cnt; r++) odd_rows += $countones(adj_rows[r] & mask) % 2;
                if (odd_rows == 0) res.euler_class = EC_EULERIAN;
                else if (odd_rows == 2) res.euler_class = EC_SEMI;
                else res.euler_class = EC_NOT;
            end
        endcase
        expected_results.push_back(res);
    endfunction

    function void check_result(logic [15:0] data);
        graph_result_t exp_res;
        graph_result_t act_res;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, data);
            errors++;
            return;
        end
        exp_res = expected_results.pop_front();
        act_res = data[DEG_W+EC_W+ST_W-1:0];
        if (act_res.degree !== exp_res.degree) begin
            $display("%0t: degree expected %0d actual %0d", $time, exp_res.degree,
                     act_res.degree);
            errors++;
        end
        if (act_res.euler_class !== exp_res.euler_class) begin
            $display("%0t: euler_class expected %0d actual %0d", $time,
                     exp_res.euler_class, act_res.euler_class);
            errors++;
        end
        if (act_res.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                     act_res.status);
            errors++;
        end
        if (data[15:DEG_W+EC_W+ST_W] !== '0) begin
            $display("%0t: padding expected 0 actual %h", $time, data[15:DEG_W+EC_W+ST_W]);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wen = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;

    degree_parity_board board;
    bit  idle_on = 1'b1;
    int  stall_left = 0;
    int  cycle_count = 0;

    graph_degree_parity_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // result side: random stall bursts while idle_on is set, check every accepted item
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] va,
                                input logic [VTX_W-1:0] vb);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, vb, va, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(cmd, va, vb);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (MAX_VERTICES_DEF + 8) @(posedge aclk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_vertex_count(value);
        cfg_wen <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int cnt;
        int pick;
        logic [CMD_W-1:0] cmd;
        logic [VTX_W-1:0] va;
        logic [VTX_W-1:0] vb;
        for (int i = 0; i < n_items; i++) begin
            cnt = board.active_count();
            // mostly in-range endpoints so edits actually land
            if (cnt > 0 && $urandom_range(0, 99) < 85) begin
                va = VTX_W'($urandom_range(0, cnt - 1));
                vb = VTX_W'($urandom_range(0, cnt - 1));
            end else begin
                va = VTX_W'($urandom_range(0, 15));
                vb = VTX_W'($urandom_range(0, 15));
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                cmd = CMD_INSERT;
            end else if (pick < 60) begin
                cmd = CMD_REMOVE;
                if ($urandom_range(0, 9) < 7) vb = board.pick_neighbor(va);
            end else if (pick < 80) begin
                cmd = CMD_DEGREE;
            end else begin
                cmd = CMD_EULER;
            end
            send_command(cmd, va, vb);
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-size graph after reset: empty, extremes, self loop, absent edge
        send_command(CMD_EULER, 4'd0, 4'd0);
        send_command(CMD_INSERT, 4'd0, 4'd15);
        send_command(CMD_INSERT, 4'd15, 4'd15);
        send_command(CMD_DEGREE, 4'd15, 4'd0);
        send_command(CMD_DEGREE, 4'd0, 4'd15);
        send_command(CMD_EULER, 4'd15, 4'd15);
        send_command(CMD_INSERT, 4'd3, 4'd4);
        send_command(CMD_EULER, 4'd0, 4'd0);
        send_command(CMD_REMOVE, 4'd5, 4'd6);
        send_command(CMD_REMOVE, 4'd15, 4'd0);
        send_command(CMD_REMOVE, 4'd15, 4'd15);
        send_command(CMD_EULER, 4'd0, 4'd0);
        send_command(CMD_INSERT, 4'd4, 4'd12);

        // shrunk count: out-of-range endpoints, edges beyond the count ignored
        write_vertex_count(5'd5);
        send_command(CMD_INSERT, 4'd4, 4'd5);
        send_command(CMD_REMOVE, 4'd7, 4'd0);
        send_command(CMD_DEGREE, 4'd5, 4'd0);
        send_command(CMD_DEGREE, 4'd4, 4'd15);
        send_command(CMD_EULER, 4'd0, 4'd0);

        write_vertex_count(5'd0);
        send_command(CMD_EULER, 4'd0, 4'd0);
        send_command(CMD_INSERT, 4'd0, 4'd0);
        send_command(CMD_DEGREE, 4'd0, 4'd0);

        // above the limit clamps to full size
        write_vertex_count(5'd31);
        send_command(CMD_DEGREE, 4'd4, 4'd0);
        send_command(CMD_EULER, 4'd0, 4'd0);

        write_vertex_count(5'd16);
        random_traffic(120);
        write_vertex_count(5'd6);
        random_traffic(100);
        write_vertex_count(5'd2);
        random_traffic(50);
        write_vertex_count(5'd1);
        random_traffic(30);
        write_vertex_count(5'd0);
        random_traffic(20);
        write_vertex_count(5'd31);
        random_traffic(100);
        write_vertex_count(5'($urandom_range(3, 15)));
        random_traffic(100);
        write_vertex_count(5'($urandom_range(17, 30)));
        random_traffic(80);
        write_vertex_count(5'd16);
        idle_on = 1'b0;
        random_traffic(100);

        drain();
        if (board.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
design/gdp_pkg.sv
design/gdp_ram.sv
design/graph_degree_parity_engine.sv
sim/testbench.sv
